/* rtl/steq_pkg.sv */
// shared types and constants of the sorted timer event queue
`timescale 1ns / 1ps
package steq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TICKS_PER_MS = 1000;
  localparam int TIME_BITS    = 48;
  localparam int MAX_RESULTS  = 16;

  localparam int DELAY_W = 20;
  localparam int TAG_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TICKS_W = $clog2(TICKS_PER_MS + 1);
  localparam int SPAN_W  = DELAY_W + TICKS_W;
  localparam int SUM_W   = ((SPAN_W > TIME_BITS) ? SPAN_W : TIME_BITS) + 1;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int POPN_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_SUM,
    ST_FIND,
    ST_PLACE,
    ST_REJECT,
    ST_ADVANCE,
    ST_CHECK,
    ST_POP
  } state_t;

  typedef struct packed {
    logic load;     // capture the item fields
    logic span;     // delay times ticks per ms
    logic sum;      // add to time and saturate
    logic find;     // compare deadline against every entry
    logic place;    // insert entry, emit accepted
    logic reject;   // emit rejected
    logic advance;  // time plus one, clear pop count
    logic pop;      // emit head, shift queue down
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic head_due;
    logic pop_last;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/steq_ctrl.sv */
// controller state machine of the sorted timer event queue
`timescale 1ns / 1ps
module steq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_set,
  output logic                in_ready,
  input  steq_pkg::dp_status_t status,
  output steq_pkg::dp_cmd_t    cmd
);
  import steq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_set == CMD_SET) begin
            state_next = status.full ? ST_REJECT : ST_SPAN;
          end else begin
            state_next = ST_ADVANCE;
          end
        end
      end
      ST_SPAN:    state_next = ST_SUM;
      ST_SUM:     state_next = ST_FIND;
      ST_FIND:    state_next = ST_PLACE;
      ST_PLACE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_REJECT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_ADVANCE: state_next = ST_CHECK;
      ST_CHECK:   state_next = status.head_due ? ST_POP : ST_IDLE;
      ST_POP: begin
        if (status.out_free && status.pop_last) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SPAN:    cmd.span = 1'b1;
      ST_SUM:     cmd.sum = 1'b1;
      ST_FIND:    cmd.find = 1'b1;
      ST_PLACE:   cmd.place = status.out_free;
      ST_REJECT:  cmd.reject = status.out_free;
      ST_ADVANCE: cmd.advance = 1'b1;
      ST_CHECK:   cmd = '0;
      ST_POP:     cmd.pop = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

/* rtl/steq_dpath.sv */
// datapath: time base, sorted entry array, deadline arithmetic, result register
`timescale 1ns / 1ps
module steq_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [steq_pkg::DELAY_W-1:0]         in_delay,
  input  logic [steq_pkg::TAG_W-1:0]           in_tag,
  input  steq_pkg::dp_cmd_t                    cmd,
  output steq_pkg::dp_status_t                 status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [steq_pkg::TAG_W-1:0]           out_tag,
  output logic [steq_pkg::KIND_W-1:0]          out_kind,
  output logic                                 out_last
);
  import steq_pkg::*;

  logic [TIME_BITS-1:0] time_now;
  logic [CNT_W-1:0]     entry_count;
  logic [POPN_W-1:0]    pop_n;

  logic [TIME_BITS-1:0] deadline_store [QUEUE_DEPTH];
  logic [TAG_W-1:0]     tag_store      [QUEUE_DEPTH];

  logic [DELAY_W-1:0]   item_delay;
  logic [TAG_W-1:0]     item_tag;
  logic [SPAN_W-1:0]    span;
  logic [TIME_BITS-1:0] new_dl;
  logic [QUEUE_DEPTH-1:0] lt;
  logic [SUM_W-1:0]     sum;

  assign sum = SUM_W'(time_now) + SUM_W'(span);

  // item capture and deadline arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_delay <= in_delay;
      item_tag   <= in_tag;
    end
    if (cmd.span) begin
      span <= SPAN_W'(item_delay) * SPAN_W'(TICKS_PER_MS);
    end
    if (cmd.sum) begin
      if (sum[SUM_W-1:TIME_BITS] != '0) begin
        new_dl <= '1;
      end else begin
        new_dl <= sum[TIME_BITS-1:0];
      end
    end
  end

  // per-entry compare flags, monotonic across the sorted array
  always_ff @(posedge clk) begin
    if (cmd.find) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        lt[i] <= (CNT_W'(i) < entry_count) && (deadline_store[i] < new_dl);
      end
    end
  end

  // entry array: insert by local shift up, pop by shift down
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.place && !lt[i]) begin
        if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
          deadline_store[i] <= new_dl;
          tag_store[i]      <= item_tag;
        end else begin
          deadline_store[i] <= deadline_store[(i == 0) ? 0 : i - 1];
          tag_store[i]      <= tag_store[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.pop && i < QUEUE_DEPTH - 1) begin
        deadline_store[i] <= deadline_store[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        tag_store[i]      <= tag_store[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      entry_count <= '0;
      pop_n       <= '0;
    end else begin
      if (cmd.advance) begin
        time_now <= time_now + TIME_BITS'(1);
        pop_n    <= '0;
      end
      if (cmd.place) begin
        entry_count <= entry_count + CNT_W'(1);
      end else if (cmd.pop) begin
        entry_count <= entry_count - CNT_W'(1);
        pop_n       <= pop_n + POPN_W'(1);
      end
    end
  end

  // status toward the controller
  logic next_due;
  assign next_due = (entry_count > CNT_W'(1))
                 && (deadline_store[(QUEUE_DEPTH > 1) ? 1 : 0] <= time_now)
                 && (pop_n != POPN_W'(MAX_RESULTS - 1));

  assign status.full     = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign status.head_due = (entry_count != '0) && (deadline_store[0] <= time_now);
  assign status.pop_last = !next_due;
  assign status.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.place || cmd.reject || cmd.pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      out_kind <= KIND_ACCEPTED;
      out_tag  <= item_tag;
      out_last <= 1'b1;
    end else if (cmd.reject) begin
      out_kind <= KIND_REJECTED;
      out_tag  <= item_tag;
      out_last <= 1'b1;
    end else if (cmd.pop) begin
      out_kind <= KIND_EXPIRED;
      out_tag  <= tag_store[0];
      out_last <= !next_due;
    end
  end

endmodule

/* rtl/sorted_timer_event_queue.sv */
// top level of the sorted timer event queue
`timescale 1ns / 1ps
// sorted timer event queue: many one-shot timers share one time base. a set
// item (tuser = 1) turns delay_ms into the deadline time_now + delay_ms * ticks
// per ms, saturated to the largest time value, and inserts it with its tag into
// a 16-entry array kept sorted by deadline, newest first among equal deadlines;
// it answers with one item, kind accepted (0) or rejected when full (1), tlast
// set. a tick item (tuser = 0) advances time by one and then emits every entry
// now due, head first, kind expired (2), tlast on the final one; a tick with
// nothing due gives no item. a set steps through capture, multiply, add and
// saturate, compare against all entries and shift-insert; a rejected set through
// capture and reject, a tick through advance, check and one pop per expired item.
// one item is worked on at a time through the controller state machine; the
// result register lets the next item be taken while the last result still
// waits, and stalls on m_tready only hold the state that wants to emit.
module sorted_timer_event_queue (
  input  logic                                clk,
  input  logic                                rst,
  // input item
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [steq_pkg::IN_DATA_W-1:0]      s_tdata,   // delay_ms[19:0], tag[35:20], zero pad
  input  logic                                s_tuser,   // command
  // result item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [steq_pkg::OUT_DATA_W-1:0]     m_tdata,   // tag[15:0] of the set or expired entry
  output logic [steq_pkg::KIND_W-1:0]         m_tuser,   // kind
  output logic                                m_tlast    // last
);
  import steq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller sequences capture, arithmetic, insert and the pop loop
  steq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_set   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath owns time, entries and the result register
  steq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_delay  (s_tdata[DELAY_W-1:0]),
    .in_tag    (s_tdata[DELAY_W+TAG_W-1:DELAY_W]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tag   (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
